>>> rtl/core/clr_pkg.sv
// Shared types and constants for the clipped line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package clr_pkg;

  // Configuration register width and reset values
  localparam int REG_BITS = 13;
  localparam logic [REG_BITS-1:0] FB_WIDTH_RESET  = 13'd640;
  localparam logic [REG_BITS-1:0] FB_HEIGHT_RESET = 13'd480;

  // Configuration register indexes
  localparam int REG_IDX_BITS = 1;
  localparam logic [REG_IDX_BITS-1:0] REG_FB_WIDTH  = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_FB_HEIGHT = 1'b1;

  // Item operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Packed ARGB colour
  localparam int CHAN_BITS  = 8;
  localparam int COLOR_BITS = 4 * CHAN_BITS;

  // Per-point flags handed from the stepper to the clipping stage
  typedef struct packed {
    logic active;
    logic last;
  } clr_flags_t;

  localparam int FLAGS_BITS = $bits(clr_flags_t);

endpackage

`default_nettype wire

>>> rtl/core/clr_fifo.sv
// Small first-in first-out queue between the line stepper and the clipping stage.
`timescale 1ns / 1ps
`default_nettype none

module clr_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entries[rd_ptr];

  // Store a beat at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/clr_front.sv
// Line stepper: holds the Bresenham state and produces one point per accepted item.
`timescale 1ns / 1ps
`default_nettype none

module clr_front #(
  parameter int COORD_BITS = 14
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic                             op,
  input  wire logic signed [COORD_BITS-1:0]     x_start,
  input  wire logic signed [COORD_BITS-1:0]     y_start,
  input  wire logic signed [COORD_BITS-1:0]     x_end,
  input  wire logic signed [COORD_BITS-1:0]     y_end,
  input  wire logic [clr_pkg::COLOR_BITS-1:0]   color,
  output logic signed [COORD_BITS-1:0]          pt_x,
  output logic signed [COORD_BITS-1:0]          pt_y,
  output clr_pkg::clr_flags_t                   pt_flags,
  output logic [clr_pkg::COLOR_BITS-1:0]        pt_color
);

  import clr_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;   // signed endpoint difference
  localparam int EW = C + 3;   // error term
  localparam int E2 = EW + 1;  // doubled error term

  // Stepper state
  logic signed [C-1:0]  cur_x, cur_y, goal_x, goal_y;
  logic signed [DW-1:0] abs_dx, neg_abs_dy;
  logic                 dir_x, dir_y;
  logic signed [EW-1:0] err_term;
  logic [COLOR_BITS-1:0] line_color;
  logic                 running;

  logic signed [C-1:0]  cur_x_next, cur_y_next, goal_x_next, goal_y_next;
  logic signed [DW-1:0] abs_dx_next, neg_abs_dy_next;
  logic                 dir_x_next, dir_y_next;
  logic signed [EW-1:0] err_term_next;
  logic [COLOR_BITS-1:0] line_color_next;
  logic                 running_next;

  logic signed [DW-1:0] dx, dy;
  logic signed [E2-1:0] e2;
  logic                 stop;
  logic                 active;
  logic                 at_goal;

  // Start-of-line deltas from the incoming endpoints
  assign dx = DW'(x_end) - DW'(x_start);
  assign dy = DW'(y_end) - DW'(y_start);
  assign e2 = $signed({err_term, 1'b0});

  // Work out the next point and state
  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    goal_x_next     = goal_x;
    goal_y_next     = goal_y;
    abs_dx_next     = abs_dx;
    neg_abs_dy_next = neg_abs_dy;
    dir_x_next      = dir_x;
    dir_y_next      = dir_y;
    err_term_next   = err_term;
    line_color_next = line_color;
    stop            = 1'b0;
    active          = 1'b0;
    if (op == OP_START) begin
      cur_x_next      = x_start;
      cur_y_next      = y_start;
      goal_x_next     = x_end;
      goal_y_next     = y_end;
      abs_dx_next     = dx[DW-1] ? -dx : dx;
      neg_abs_dy_next = dy[DW-1] ? dy : -dy;
      dir_x_next      = !(x_start < x_end);
      dir_y_next      = !(y_start < y_end);
      err_term_next   = EW'(abs_dx_next) + EW'(neg_abs_dy_next);
      line_color_next = color;
      active          = 1'b1;
    end else if (running) begin
      active = 1'b1;
      // Horizontal move
      if (e2 >= E2'(neg_abs_dy)) begin
        if (cur_x == goal_x) begin
          stop = 1'b1;
        end else begin
          err_term_next = err_term + EW'(neg_abs_dy);
          cur_x_next    = dir_x ? cur_x - C'(1) : cur_x + C'(1);
        end
      end
      // Vertical move, keeping any horizontal move already made
      if (!stop && (e2 <= E2'(abs_dx))) begin
        if (cur_y == goal_y) begin
          stop = 1'b1;
        end else begin
          err_term_next = err_term_next + EW'(abs_dx);
          cur_y_next    = dir_y ? cur_y - C'(1) : cur_y + C'(1);
        end
      end
      if (stop) begin
        active = 1'b0;
      end
    end
    at_goal = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
    if (op == OP_START) begin
      running_next = !at_goal;
    end else begin
      running_next = running && !stop && !at_goal;
    end
  end

  // Hand the point to the queue
  assign pt_x            = cur_x_next;
  assign pt_y            = cur_y_next;
  assign pt_flags.active = active;
  assign pt_flags.last   = at_goal;
  assign pt_color        = line_color_next;

  // Update state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      goal_x     <= '0;
      goal_y     <= '0;
      abs_dx     <= '0;
      neg_abs_dy <= '0;
      dir_x      <= 1'b0;
      dir_y      <= 1'b0;
      err_term   <= '0;
      line_color <= '0;
      running    <= 1'b0;
    end else if (accept) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      goal_x     <= goal_x_next;
      goal_y     <= goal_y_next;
      abs_dx     <= abs_dx_next;
      neg_abs_dy <= neg_abs_dy_next;
      dir_x      <= dir_x_next;
      dir_y      <= dir_y_next;
      err_term   <= err_term_next;
      line_color <= line_color_next;
      running    <= running_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/clr_back.sv
// Clipping and address stage: bounds check, y * width + x, and the result register.
`timescale 1ns / 1ps
`default_nettype none

module clr_back #(
  parameter int COORD_BITS = 14,
  parameter int ADDR_BITS  = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [COORD_BITS-1:0]   in_x,
  input  wire logic signed [COORD_BITS-1:0]   in_y,
  input  wire clr_pkg::clr_flags_t            in_flags,
  input  wire logic [clr_pkg::COLOR_BITS-1:0] in_color,
  input  wire logic [clr_pkg::REG_BITS-1:0]   fb_width,
  input  wire logic [clr_pkg::REG_BITS-1:0]   fb_height,
  output logic                                out_valid,
  input  wire logic                           out_take,
  output logic [ADDR_BITS-1:0]                pixel_address,
  output logic [clr_pkg::COLOR_BITS-1:0]      pixel_value,
  output logic                                write_enable,
  output logic signed [COORD_BITS-1:0]        point_x,
  output logic signed [COORD_BITS-1:0]        point_y,
  output logic                                last
);

  import clr_pkg::*;

  localparam int MAG_W  = COORD_BITS - 1;
  localparam int CMP_W  = (MAG_W > REG_BITS) ? MAG_W : REG_BITS;
  localparam int PROD_W = MAG_W + REG_BITS;
  localparam int SUM_W  = PROD_W + 1;

  logic [MAG_W-1:0] x_mag, y_mag;
  logic             in_frame;

  logic                   s1_valid;
  logic signed [COORD_BITS-1:0] s1_x, s1_y;
  logic                   s1_in_frame;
  logic                   s1_last;
  logic [COLOR_BITS-1:0]  s1_color;
  logic [PROD_W-1:0]      s1_prod;
  logic                   out_free;
  logic                   s1_go;
  logic [SUM_W-1:0]       addr_sum;

  // Bounds check on the incoming point
  assign x_mag    = in_x[MAG_W-1:0];
  assign y_mag    = in_y[MAG_W-1:0];
  assign in_frame = in_flags.active && !in_x[COORD_BITS-1] && !in_y[COORD_BITS-1] &&
                    (CMP_W'(x_mag) < CMP_W'(fb_width)) &&
                    (CMP_W'(y_mag) < CMP_W'(fb_height));

  // Stage handshakes
  assign out_free = !out_valid || out_take;
  assign s1_go    = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // Row offset stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_x        <= in_x;
      s1_y        <= in_y;
      s1_in_frame <= in_frame;
      s1_last     <= in_flags.last;
      s1_color    <= in_color;
      s1_prod     <= PROD_W'(y_mag) * PROD_W'(fb_width);
    end
  end

  // Add the column and wrap to the address width
  assign addr_sum = SUM_W'(s1_prod) + SUM_W'(s1_x[MAG_W-1:0]);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      pixel_address <= s1_in_frame ? ADDR_BITS'(addr_sum) : '0;
      pixel_value   <= s1_color;
      write_enable  <= s1_in_frame;
      point_x       <= s1_x;
      point_y       <= s1_y;
      last          <= s1_last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/clipped_line_rasterizer_top.sv
// Top level of the clipped line rasterizer: stepper, point queue and clipping stage.
//
// Input channel (push / full): one beat is a start (op = 0, latches endpoints
// and colour, yields the first point) or a step (op = 1, yields the next point).
// Every beat yields exactly one result beat on the output channel (empty / pop):
// pixel address y * fb_width + x, ARGB value, write enable (cleared outside the
// framebuffer or once the line has ended), the point and a last flag.
// Throughput: one beat per cycle in and out unless full or a low pop holds the flow;
// the stepper finishes each point in the cycle it accepts the beat, so successive
// steps follow back to back. A result passes through the point queue, the
// row-offset multiply register and the result register before it is visible.
// While pop is low results back up into the four-entry point queue; full rises
// once it fills, and the stepper then waits without losing state.
// Reset empties the queue and pipeline, clears the line state to a point at the
// origin with no line active, and loads width 640 and height 480.
// fb_width and fb_height are written through cfg_write / cfg_index / cfg_data and
// should only change while no results are outstanding.
`timescale 1ns / 1ps
`default_nettype none

module clipped_line_rasterizer_top #(
  parameter int COORD_BITS = 14,
  parameter int ADDR_BITS  = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               op,
  input  wire logic signed [COORD_BITS-1:0]       x_start,
  input  wire logic signed [COORD_BITS-1:0]       y_start,
  input  wire logic signed [COORD_BITS-1:0]       x_end,
  input  wire logic signed [COORD_BITS-1:0]       y_end,
  input  wire logic [clr_pkg::CHAN_BITS-1:0]      alpha,
  input  wire logic [clr_pkg::CHAN_BITS-1:0]      red,
  input  wire logic [clr_pkg::CHAN_BITS-1:0]      green,
  input  wire logic [clr_pkg::CHAN_BITS-1:0]      blue,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [ADDR_BITS-1:0]                    pixel_address,
  output logic [clr_pkg::COLOR_BITS-1:0]          pixel_value,
  output logic                                    write_enable,
  output logic signed [COORD_BITS-1:0]            point_x,
  output logic signed [COORD_BITS-1:0]            point_y,
  output logic                                    last,
  input  wire logic                               cfg_write,
  input  wire logic [clr_pkg::REG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [clr_pkg::REG_BITS-1:0]       cfg_data
);

  import clr_pkg::*;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_W = 2 * COORD_BITS + FLAGS_BITS + COLOR_BITS;

  logic [REG_BITS-1:0] fb_width;
  logic [REG_BITS-1:0] fb_height;

  logic                         accept;
  logic signed [COORD_BITS-1:0] pt_x, pt_y;
  clr_flags_t                   pt_flags;
  logic [COLOR_BITS-1:0]        pt_color;

  logic [Q_W-1:0]               q_in, q_out;
  logic                         q_valid;
  logic                         back_ready;
  logic signed [COORD_BITS-1:0] q_x, q_y;
  clr_flags_t                   q_flags;
  logic [COLOR_BITS-1:0]        q_color;
  logic                         res_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width  <= FB_WIDTH_RESET;
      fb_height <= FB_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FB_WIDTH:  fb_width  <= cfg_data;
        REG_FB_HEIGHT: fb_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  // Stepper
  clr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .op       (op),
    .x_start  (x_start),
    .y_start  (y_start),
    .x_end    (x_end),
    .y_end    (y_end),
    .color    ({alpha, red, green, blue}),
    .pt_x     (pt_x),
    .pt_y     (pt_y),
    .pt_flags (pt_flags),
    .pt_color (pt_color)
  );

  // Point queue
  assign q_in = {pt_x, pt_y, pt_flags, pt_color};

  clr_fifo #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (q_in),
    .full      (full),
    .pop       (back_ready),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  assign {q_x, q_y, q_flags, q_color} = q_out;

  // Clipping and address stage
  clr_back #(
    .COORD_BITS(COORD_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (q_valid),
    .in_ready      (back_ready),
    .in_x          (q_x),
    .in_y          (q_y),
    .in_flags      (q_flags),
    .in_color      (q_color),
    .fb_width      (fb_width),
    .fb_height     (fb_height),
    .out_valid     (res_valid),
    .out_take      (pop),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .write_enable  (write_enable),
    .point_x       (point_x),
    .point_y       (point_y),
    .last          (last)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

>>> dv/clipped_line_rasterizer_top_test.sv
// Self-checking testbench for the clipped line rasterizer: directed table, random lines, checks.
`timescale 1ns / 1ps

module clipped_line_rasterizer_top_test;
  import clr_pkg::*;

  localparam int COORD_BITS   = 14;
  localparam int ADDR_BITS    = 24;
  localparam int DIR_ROWS     = 25;
  localparam int PHASES       = 6;
  localparam int PHASE_BEATS  = 280;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 80;
  localparam int COORD_MAX    = 8191;
  localparam int COORD_MIN    = -8192;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One input beat: op, endpoints and colour
  typedef struct {
    logic   op;
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    logic [CHAN_BITS-1:0] alpha;
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } beat_t;

  // One output pixel beat
  typedef struct packed {
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] value;
    logic                  we;
    coord_t                x;
    coord_t                y;
    logic                  last;
  } pix_t;

  typedef struct {
    beat_t beat;
    bit    typed;
    pix_t  want;
  } dir_row_t;

  localparam pix_t NO_PIX = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic op = OP_START;
  coord_t x_start = '0;
  coord_t y_start = '0;
  coord_t x_end = '0;
  coord_t y_end = '0;
  logic [CHAN_BITS-1:0] alpha = '0;
  logic [CHAN_BITS-1:0] red = '0;
  logic [CHAN_BITS-1:0] green = '0;
  logic [CHAN_BITS-1:0] blue = '0;
  logic empty;
  logic pop = 1'b0;
  logic [ADDR_BITS-1:0] pixel_address;
  logic [COLOR_BITS-1:0] pixel_value;
  logic write_enable;
  coord_t point_x;
  coord_t point_y;
  logic last;
  logic cfg_write = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_index = REG_FB_WIDTH;
  logic [REG_BITS-1:0] cfg_data = '0;

  clipped_line_rasterizer_top #(
    .COORD_BITS(COORD_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rasteriser state mirrored by the testbench
  coord_t pen_x = '0, pen_y = '0, goal_x = '0, goal_y = '0;
  int run_dx = 0, run_ndy = 0, bres_err = 0;
  bit step_neg_x = 1'b0, step_neg_y = 1'b0;
  logic [COLOR_BITS-1:0] ink = '0;
  bit drawing = 1'b0;
  int fb_w = 640;
  int fb_h = 480;

  pix_t pending_pixels [$];
  int fault_count = 0;
  int beats_sent = 0;
  int lines_started = 0;
  int pixels_checked = 0;
  int pixels_written = 0;
  int settings_seen = 1;
  int burst_left = 0;

  // Directed table: expected beat typed in where it is obvious, else predicted
  dir_row_t dir_table [DIR_ROWS] = '{
    // step straight after reset repeats the origin
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{24'd0, 32'h00000000, 1'b0, 0, 0, 1'b1}},
    // single-point line inside the frame
    '{'{OP_START, 5, 3, 5, 3, 8'hAA, 8'h55, 8'h0F, 8'hF0}, 1'b1,
      '{24'd1925, 32'hAA550FF0, 1'b1, 5, 3, 1'b1}},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{24'd0, 32'hAA550FF0, 1'b0, 5, 3, 1'b1}},
    // coordinate extremes, both directions
    '{'{OP_START, -8192, -8192, 8191, 8191, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
      '{24'd0, 32'hFFFFFFFF, 1'b0, -8192, -8192, 1'b0}},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX},
    '{'{OP_START, 8191, 8191, -8192, -8192, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{24'd0, 32'h00000000, 1'b0, 8191, 8191, 1'b0}},
    '{'{OP_STEP, 8191, -8192, 8191, -8192, 8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b0, NO_PIX},
    // last pixel of the frame, then just past each edge
    '{'{OP_START, 639, 479, 639, 479, 8'h12, 8'h34, 8'h56, 8'h78}, 1'b1,
      '{24'd307199, 32'h12345678, 1'b1, 639, 479, 1'b1}},
    '{'{OP_START, 640, 0, 640, 0, 8'h01, 8'h02, 8'h03, 8'h04}, 1'b1,
      '{24'd0, 32'h01020304, 1'b0, 640, 0, 1'b1}},
    '{'{OP_START, 0, 480, 2, 480, 8'h80, 8'h40, 8'h20, 8'h10}, 1'b1,
      '{24'd0, 32'h80402010, 1'b0, 0, 480, 1'b0}},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX},
    // horizontal line run to its end and beyond
    '{'{OP_START, 0, 0, 3, 0, 8'h7F, 8'h00, 8'hFF, 8'h01}, 1'b1,
      '{24'd0, 32'h7F00FF01, 1'b1, 0, 0, 1'b0}},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{24'd0, 32'h7F00FF01, 1'b0, 3, 0, 1'b1}},
    // vertical line stepping towards negative y
    '{'{OP_START, 10, 10, 10, 7, 8'hC3, 8'h3C, 8'hA5, 8'h5A}, 1'b1,
      '{24'd6410, 32'hC33CA55A, 1'b1, 10, 10, 1'b0}},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX},
    // steep line leaving the frame through the top edge
    '{'{OP_START, 0, 0, 2, -5, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1,
      '{24'd0, 32'h00FF00FF, 1'b1, 0, 0, 1'b0}},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX},
    '{'{OP_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIX}
  };

  // Build the pixel beat for the current pen position
  function automatic pix_t shade_point(bit active);
    pix_t p;
    int px, py;
    px = int'(pen_x);
    py = int'(pen_y);
    p.we = active && px >= 0 && py >= 0 && px < fb_w && py < fb_h;
    p.addr = p.we ? ADDR_BITS'(py * fb_w + px) : '0;
    p.value = ink;
    p.x = pen_x;
    p.y = pen_y;
    p.last = (pen_x == goal_x) && (pen_y == goal_y);
    return p;
  endfunction

  // Advance the line state by one beat and return the pixel it yields
  function automatic pix_t rasterise_beat(beat_t b);
    int dx, dy, e2;
    if (b.op == OP_START) begin
      pen_x = b.xs;
      pen_y = b.ys;
      goal_x = b.xe;
      goal_y = b.ye;
      dx = int'(goal_x) - int'(pen_x);
      dy = int'(goal_y) - int'(pen_y);
      run_dx = dx < 0 ? -dx : dx;
      run_ndy = dy < 0 ? dy : -dy;
      step_neg_x = !(pen_x < goal_x);
      step_neg_y = !(pen_y < goal_y);
      bres_err = run_dx + run_ndy;
      ink = {b.alpha, b.red, b.green, b.blue};
      drawing = !(pen_x == goal_x && pen_y == goal_y);
      return shade_point(1'b1);
    end
    if (!drawing) return shade_point(1'b0);
    e2 = 2 * bres_err;
    if (e2 >= run_ndy) begin
      if (pen_x == goal_x) begin
        drawing = 1'b0;
        return shade_point(1'b0);
      end
      bres_err += run_ndy;
      pen_x = step_neg_x ? pen_x - 14'sd1 : pen_x + 14'sd1;
    end
    if (e2 <= run_dx) begin
      if (pen_y == goal_y) begin
        drawing = 1'b0;
        return shade_point(1'b0);
      end
      bres_err += run_dx;
      pen_y = step_neg_y ? pen_y - 14'sd1 : pen_y + 14'sd1;
    end
    if (pen_x == goal_x && pen_y == goal_y) drawing = 1'b0;
    return shade_point(1'b1);
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s expected %0h got %0h", name, want_v, got_v);
      fault_count++;
    end
  endfunction

  // Offer one beat and hold it until accepted; predict at the accepting edge
  task automatic offer(beat_t b, bit typed, pix_t typed_px);
    pix_t want;
    push <= 1'b1;
    op <= b.op;
    x_start <= b.xs;
    y_start <= b.ys;
    x_end <= b.xe;
    y_end <= b.ye;
    alpha <= b.alpha;
    red <= b.red;
    green <= b.green;
    blue <= b.blue;
    @(posedge clk);
    while (full) @(posedge clk);
    want = rasterise_beat(b);
    pending_pixels.push_back(typed ? typed_px : want);
    beats_sent++;
    if (b.op == OP_START) lines_started++;
  endtask

  // Bursts of back-to-back beats separated by random gaps
  task automatic pause_sender();
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both frame registers on consecutive edges
  task automatic set_frame(int w, int h);
    cfg_write <= 1'b1;
    cfg_index <= REG_FB_WIDTH;
    cfg_data <= REG_BITS'(w);
    @(posedge clk);
    fb_w = w;
    cfg_index <= REG_FB_HEIGHT;
    cfg_data <= REG_BITS'(h);
    @(posedge clk);
    fb_h = h;
    cfg_write <= 1'b0;
    settings_seen++;
  endtask

  function automatic beat_t random_step();
    beat_t b;
    b.op = OP_STEP;
    b.xs = coord_t'($urandom);
    b.ys = coord_t'($urandom);
    b.xe = coord_t'($urandom);
    b.ye = coord_t'($urandom);
    {b.alpha, b.red, b.green, b.blue} = $urandom;
    return b;
  endfunction

  // One random line: mostly run to its end, sometimes cut short, rarely a lone step
  task automatic draw_random_line();
    beat_t b;
    int kind, span, sx, sy, ex, ey, adx, ady, n_steps;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      offer(random_step(), 1'b0, NO_PIX);
      pause_sender();
      return;
    end
    span = ($urandom_range(0, 9) == 0) ? 60 : 12;
    if (kind < 15) begin
      sx = int'($urandom_range(0, fb_w + 11)) - 6;
      sy = int'($urandom_range(0, fb_h + 11)) - 6;
    end else begin
      sx = int'($urandom_range(0, 16383)) + COORD_MIN;
      sy = int'($urandom_range(0, 16383)) + COORD_MIN;
    end
    ex = sx + int'($urandom_range(0, 2 * span)) - span;
    ey = sy + int'($urandom_range(0, 2 * span)) - span;
    b = random_step();
    b.op = OP_START;
    b.xs = clamp_coord(sx);
    b.ys = clamp_coord(sy);
    b.xe = clamp_coord(ex);
    b.ye = clamp_coord(ey);
    offer(b, 1'b0, NO_PIX);
    pause_sender();
    adx = int'(b.xe) - int'(b.xs);
    ady = int'(b.ye) - int'(b.ys);
    adx = adx < 0 ? -adx : adx;
    ady = ady < 0 ? -ady : ady;
    n_steps = (adx > ady ? adx : ady) + int'($urandom_range(0, 2));
    if (kind == 1) n_steps = $urandom_range(0, n_steps);
    repeat (n_steps) begin
      offer(random_step(), 1'b0, NO_PIX);
      pause_sender();
    end
  endtask

  // Receiver: check each accepted beat, stall on its own pattern
  initial begin
    pix_t got, want;
    int cyc, stall_mode, hold_left;
    logic take;
    cyc = 0;
    stall_mode = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = '{pixel_address, pixel_value, write_enable, point_x, point_y, last};
        if (pending_pixels.size() == 0) begin
          $error("pixel beat with nothing expected: address %0h", got.addr);
          fault_count++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_address", 32'(want.addr), 32'(got.addr));
          check_field("pixel_value", want.value, got.value);
          check_field("write_enable", 32'(want.we), 32'(got.we));
          check_field("point_x", 32'(want.x), 32'(got.x));
          check_field("point_y", 32'(want.y), 32'(got.y));
          check_field("last", 32'(want.last), 32'(got.last));
        end
        pixels_checked++;
        if (got.we) pixels_written++;
        // hold off long enough for the point queue to fill and stall the input
        if (pixels_checked == 150 || pixels_checked == 900) hold_left = HOLD_CYCLES;
      end
      cyc++;
      if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: take = 1'b1;
        1: take = 1'($urandom_range(0, 1));
        2: take = (cyc % 4 == 0);
        default: take = ((cyc / 4) % 2 == 0);
      endcase
      if (hold_left > 0) begin
        take = 1'b0;
        hold_left--;
      end
      pop <= take;
    end
  end

  // Stimulus
  initial begin
    int phase_w [PHASES];
    int phase_h [PHASES];
    phase_w = '{640, 0, 1, 8191, 4096, 0};
    phase_h = '{480, 37, 1, 8191, 4096, 0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_table[i]) begin
      offer(dir_table[i].beat, dir_table[i].typed, dir_table[i].want);
      pause_sender();
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain_pipeline();
        if (ph == PHASES - 1) begin
          phase_w[ph] = $urandom_range(1, 4096);
          phase_h[ph] = $urandom_range(1, 4096);
        end
        set_frame(phase_w[ph], phase_h[ph]);
      end
      while (beats_sent < DIR_ROWS + (ph + 1) * PHASE_BEATS) draw_random_line();
    end
    drain_pipeline();
    $display("Covered %0d beats in %0d lines over %0d frame sizes, zero and maximum included.",
             beats_sent, lines_started, settings_seen);
    $display("Checked %0d pixel beats: %0d written, %0d clipped or repeated.",
             pixels_checked, pixels_written, pixels_checked - pixels_written);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3ms;
    $display("Timed out with %0d pixel beats outstanding", pending_pixels.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
